[hw/rtl/ordered_array_store_unit_assert.svh]
// Assertion macros for the ordered array store.
`ifndef ORDERED_ARRAY_STORE_UNIT_ASSERT_SVH
`define ORDERED_ARRAY_STORE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define OAS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define OAS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/oas_pkg.sv]
`default_nettype none

package oas_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = 7;
	localparam int POS_W    = 7;
	localparam int VAL_W    = 32;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_APPEND = 2'd1,
		OP_SEARCH = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_MISS  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT,
		S_SCAN
	} state_t;

endpackage

`default_nettype wire

[hw/rtl/ordered_array_store_unit.sv]
// Channel   Handshake           Payload
// command   start / busy        opcode, position, value
// result    done (one cycle)    success, status, count
//
// Append, insert at the end of the list, and any rejected operation give their result
// straight from the idle state; so do search and remove on an empty store.
// Insert at position p below the count n reads entries n - 1 down to p, writes each one
// place up, then stores the value at p. Search and remove go through all n stored entries.
// Both walks use the single read and single write port of the entry memory.
// Reset clears the count and control state; the memory needs no clearing, and results cannot be stalled.
`default_nettype none

`include "ordered_array_store_unit_assert.svh"

module ordered_array_store_unit
	import oas_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [1:0]              opcode,
	input  wire logic [POS_W-1:0]        position,
	input  wire logic signed [VAL_W-1:0] value,
	output logic                         done,
	output logic                         success,
	output logic [1:0]                   status,
	output logic [CNT_W-1:0]             count
);

	logic [VAL_W-1:0] mem [CAPACITY];

	state_t           state_q, state_d;
	logic [IDX_W-1:0] addr_q, addr_d;
	logic             iss_q, iss_d;
	logic             found_q, found_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             done_q, done_d;
	logic             success_q, success_d;
	status_t          status_q, status_d;
	logic             rd_vld_s1, rd_vld_d;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [VAL_W-1:0] rdata_s1;
	op_t              op_q;
	logic [IDX_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;
	logic             load;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [VAL_W-1:0] wdata;
	logic [IDX_W-1:0] last_idx;

	assign last_idx = IDX_W'(cnt_q - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		addr_d    = addr_q;
		iss_d     = iss_q;
		found_d   = found_q;
		cnt_d     = cnt_q;
		done_d    = 1'b0;
		success_d = success_q;
		status_d  = status_q;
		rd_vld_d  = 1'b0;
		load      = 1'b0;
		we        = 1'b0;
		waddr     = addr_q;
		wdata     = VAL_W'(value);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					load = 1'b1;
					unique case (op_t'(opcode))
						OP_INSERT: begin
							if (position > cnt_q) begin
								done_d    = 1'b1;
								success_d = 1'b0;
								status_d  = STAT_RANGE;
							end else if (cnt_q == CNT_W'(CAPACITY)) begin
								done_d    = 1'b1;
								success_d = 1'b0;
								status_d  = STAT_FULL;
							end else if (position == cnt_q) begin
								we        = 1'b1;
								waddr     = IDX_W'(position);
								cnt_d     = cnt_q + CNT_W'(1);
								done_d    = 1'b1;
								success_d = 1'b1;
								status_d  = STAT_OK;
							end else begin
								state_d = S_SHIFT;
								addr_d  = last_idx;
								iss_d   = 1'b1;
							end
						end
						OP_APPEND: begin
							if (cnt_q == CNT_W'(CAPACITY)) begin
								done_d    = 1'b1;
								success_d = 1'b0;
								status_d  = STAT_FULL;
							end else begin
								we        = 1'b1;
								waddr     = IDX_W'(cnt_q);
								cnt_d     = cnt_q + CNT_W'(1);
								done_d    = 1'b1;
								success_d = 1'b1;
								status_d  = STAT_OK;
							end
						end
						OP_SEARCH, OP_REMOVE: begin
							if (cnt_q == '0) begin
								done_d    = 1'b1;
								success_d = 1'b0;
								status_d  = STAT_MISS;
							end else begin
								state_d = S_SCAN;
								addr_d  = '0;
								iss_d   = 1'b1;
								found_d = 1'b0;
							end
						end
						default: begin
							done_d = 1'b0;
						end
					endcase
				end
			end
			S_SHIFT: begin
				// Reads walk downwards from the top entry; each beat is written one place up.
				if (iss_q) begin
					rd_vld_d = 1'b1;
					if (addr_q == pos_q) begin
						iss_d = 1'b0;
					end else begin
						addr_d = addr_q - IDX_W'(1);
					end
				end
				if (rd_vld_s1) begin
					we    = 1'b1;
					waddr = rd_idx_s1 + IDX_W'(1);
					wdata = rdata_s1;
				end else if (!iss_q) begin
					we        = 1'b1;
					waddr     = pos_q;
					wdata     = val_q;
					cnt_d     = cnt_q + CNT_W'(1);
					done_d    = 1'b1;
					success_d = 1'b1;
					status_d  = STAT_OK;
					state_d   = S_IDLE;
				end
			end
			S_SCAN: begin
				// After the first match, a removal copies each later entry one place down.
				if (iss_q) begin
					rd_vld_d = 1'b1;
					if (addr_q == last_idx) begin
						iss_d = 1'b0;
					end else begin
						addr_d = addr_q + IDX_W'(1);
					end
				end
				if (rd_vld_s1) begin
					if (found_q && op_q == OP_REMOVE) begin
						we    = 1'b1;
						waddr = rd_idx_s1 - IDX_W'(1);
						wdata = rdata_s1;
					end else if (rdata_s1 == val_q) begin
						found_d = 1'b1;
					end
				end else if (!iss_q) begin
					done_d    = 1'b1;
					success_d = found_q;
					status_d  = found_q ? STAT_OK : STAT_MISS;
					if (found_q && op_q == OP_REMOVE) begin
						cnt_d = cnt_q - CNT_W'(1);
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			iss_q     <= 1'b0;
			found_q   <= 1'b0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
			success_q <= 1'b0;
			status_q  <= STAT_OK;
			rd_vld_s1 <= 1'b0;
		end else begin
			addr_q    <= addr_d;
			iss_q     <= iss_d;
			found_q   <= found_d;
			cnt_q     <= cnt_d;
			done_q    <= done_d;
			success_q <= success_d;
			status_q  <= status_d;
			rd_vld_s1 <= rd_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_q  <= op_t'(opcode);
			pos_q <= IDX_W'(position);
			val_q <= VAL_W'(value);
		end
		if (rd_vld_d) begin
			rd_idx_s1 <= addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[addr_q];
	end

	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign success = success_q;
	assign status  = status_q;
	assign count   = cnt_q;

	`OAS_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= CNT_W'(CAPACITY), "count above capacity")
	`OAS_ASSERT_NXT(a_accept_progress, start && !busy, busy || done, "accepted beat dropped")
	`OAS_ASSERT_NOW(a_flag_status, done, success == (status == STAT_OK), "flag and status disagree")
	`OAS_ASSERT_NOW(a_read_in_work, rd_vld_s1, busy, "read in flight while idle")
	`OAS_ASSERT_NXT(a_count_hold, !busy && !start, $stable(cnt_q), "count changed while idle")

endmodule

`default_nettype wire
